>>> design/sfov_pkg.sv
// shared types and constants for the shadowcast field-of-view block
// depends on nothing; imported by the controller, datapath and top level
package sfov_pkg;

  localparam int MAP_SIDE_MAX_DEF = 64;
  localparam int RADIUS_MAX_DEF   = 31;
  localparam int CFG_W            = 7;

  // action codes
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // register indexes
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // octant transform coefficients
  localparam logic signed [1:0] OCT_XX [8] = '{2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1};
  localparam logic signed [1:0] OCT_XY [8] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0};
  localparam logic signed [1:0] OCT_YX [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd0};
  localparam logic signed [1:0] OCT_YY [8] = '{2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1};

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic wr_opq;
    logic out_now;
    logic out_read;
    logic out_fin;
    logic sweep_all;
    logic sweep_vis;
    logic origin_mark;
    logic oct_init;
    logic oct_next;
    logic step;
    logic pop_load;
    logic test;
    logic mark;
  } sfov_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic visit;
    logic active;
    logic stack_empty;
    logic oct_last;
    logic test_pass;
  } sfov_stat_t;

endpackage

>>> design/sfov_datapath.sv
// datapath: tile memories, scan frame and frame stack, slope and range arithmetic
// depends on sfov_pkg
module sfov_datapath import sfov_pkg::*; #(
  parameter int MAP_SIDE_MAX = MAP_SIDE_MAX_DEF,
  parameter int RADIUS_MAX   = RADIUS_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  sfov_cmd_t        cmd,
  output sfov_stat_t       stat,
  input  logic             cfg_write_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [1:0]       action,
  input  logic [5:0]       tile_x,
  input  logic [5:0]       tile_y,
  input  logic             opaque_in,
  input  logic [4:0]       view_radius,
  output logic             visible_out,
  output logic             explored_out,
  output logic             in_map
);

  localparam int XW = $clog2(MAP_SIDE_MAX);
  localparam int AW = 2 * XW;
  localparam int JW = $clog2(RADIUS_MAX + 2);
  localparam int DW = JW + 1;
  localparam int SW = JW + 3;
  localparam int CW = JW + 10;
  localparam int PW = 2 * SW;
  localparam int QW = 2 * JW + 1;
  localparam int IW = (RADIUS_MAX > 1) ? $clog2(RADIUS_MAX) : 1;
  localparam int NW = $clog2(RADIUS_MAX + 1);
  localparam logic signed [CW-1:0] SIDE_S = CW'(MAP_SIDE_MAX);
  localparam logic signed [DW-1:0] DX_ONE = DW'(1);
  localparam logic signed [SW-1:0] S_ONE  = SW'(1);
  localparam logic signed [SW-1:0] S_ZERO = SW'(0);

  typedef struct packed {
    logic [JW-1:0]        j;
    logic signed [DW-1:0] dx;
    logic signed [SW-1:0] sn;
    logic signed [SW-1:0] sd;
    logic signed [SW-1:0] en;
    logic signed [SW-1:0] ed;
    logic signed [SW-1:0] nn;
    logic signed [SW-1:0] nd;
    logic                 blocked;
  } frame_t;

  function automatic logic signed [CW-1:0] scale(input logic signed [CW-1:0] v,
                                                  input logic signed [1:0] c);
    logic signed [CW-1:0] r;
    case (c)
      2'sd1:   r = v;
      -2'sd1:  r = -v;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic slope_less(input logic signed [SW-1:0] a, b, c, d);
    return (PW'(a) * PW'(d)) < (PW'(c) * PW'(b));
  endfunction

  logic [CFG_W-1:0] map_width, map_height;
  logic signed [CW-1:0] width_s, height_s;

  logic opq_mem [2**AW];
  logic vis_mem [2**AW];
  logic exp_mem [2**AW];
  frame_t stack_mem [RADIUS_MAX];

  logic signed [CW-1:0] ox, oy, in_x, in_y, mx, my, j_c, dx_c;
  logic [AW-1:0] in_addr, o_addr, step_addr, rd_addr, m_addr, clr_addr;
  logic in_inside, step_inside, orig_in, m_in, dist_ok;
  logic [JW-1:0] r, r_in, jn, dxm;
  logic [2*JW-1:0] r2;
  logic [QW-1:0] dsum;
  logic [2:0] oct;
  frame_t fr, f_mark, f_new, stk_rd;
  logic active, dx_pos, j_over, do_push, can_push, opaque;
  logic [NW-1:0] sp;
  logic signed [SW-1:0] dxe, je, ln, ld, rn, rd, ln_r, ld_r, rn_r, rd_r;
  logic c1, c2, c3;
  logic opq_rd, vis_rd, exp_rd;
  logic vis_o, exp_o, inm_o;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= CFG_W'(64);
      map_height <= CFG_W'(64);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_s  = signed'({{(CW-CFG_W){1'b0}}, map_width});
  assign height_s = signed'({{(CW-CFG_W){1'b0}}, map_height});

  assign in_x = signed'({{(CW-6){1'b0}}, tile_x});
  assign in_y = signed'({{(CW-6){1'b0}}, tile_y});
  assign in_inside = (in_x < width_s) && (in_x < SIDE_S) && (in_y < height_s) && (in_y < SIDE_S);
  assign in_addr = {in_y[XW-1:0], in_x[XW-1:0]};
  assign r_in = (int'(view_radius) > RADIUS_MAX) ? JW'(RADIUS_MAX) : JW'(view_radius);

  // tile coordinates of the frame's current cell
  assign j_c  = signed'(CW'({1'b0, fr.j}));
  assign dx_c = CW'(fr.dx);
  assign mx = ox + scale(dx_c, OCT_XX[oct]) - scale(j_c, OCT_XY[oct]);
  assign my = oy + scale(dx_c, OCT_YX[oct]) - scale(j_c, OCT_YY[oct]);
  assign step_inside = (mx >= 0) && (my >= 0) && (mx < width_s) && (mx < SIDE_S)
                       && (my < height_s) && (my < SIDE_S);
  assign step_addr = {my[XW-1:0], mx[XW-1:0]};
  assign rd_addr = cmd.step ? step_addr : in_addr;

  // doubled edge slopes
  assign dxe = SW'(fr.dx);
  assign je  = signed'(SW'({1'b0, fr.j}));
  assign ln = S_ONE - (dxe <<< 1);
  assign ld = (je <<< 1) - S_ONE;
  assign rn = -(dxe <<< 1) - S_ONE;
  assign rd = (je <<< 1) + S_ONE;

  assign dxm  = JW'(-fr.dx);
  assign dsum = QW'((2*JW)'(dxm) * (2*JW)'(dxm)) + QW'((2*JW)'(fr.j) * (2*JW)'(fr.j));

  assign dx_pos = fr.dx > 0;
  assign j_over = fr.j > r;
  assign jn = fr.j + JW'(1);

  assign c1 = slope_less(fr.sn, fr.sd, rn_r, rd_r);
  assign c2 = slope_less(ln_r, ld_r, fr.en, fr.ed);
  assign c3 = slope_less(fr.sn, fr.sd, ln_r, ld_r);
  assign opaque = m_in && opq_rd;
  assign can_push = !c3 && (int'(sp) + 1 < RADIUS_MAX);

  always_comb begin
    f_mark = fr;
    f_mark.dx = fr.dx + DX_ONE;
    do_push = 1'b0;
    if (fr.blocked) begin
      if (opaque) begin
        f_mark.nn = rn_r;
        f_mark.nd = rd_r;
      end else begin
        f_mark.blocked = 1'b0;
        f_mark.sn = fr.nn;
        f_mark.sd = fr.nd;
      end
    end else if (opaque && fr.j < r) begin
      f_mark.blocked = 1'b1;
      f_mark.nn = rn_r;
      f_mark.nd = rd_r;
      do_push = can_push;
    end
    f_new.j       = jn;
    f_new.dx      = -signed'({1'b0, jn});
    f_new.sn      = fr.sn;
    f_new.sd      = fr.sd;
    f_new.en      = ln_r;
    f_new.ed      = ld_r;
    f_new.nn      = S_ZERO;
    f_new.nd      = S_ONE;
    f_new.blocked = 1'b0;
  end

  // item capture and per-visit registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ox      <= in_x;
      oy      <= in_y;
      o_addr  <= in_addr;
      orig_in <= in_inside;
      r       <= r_in;
      r2      <= (2*JW)'(r_in) * (2*JW)'(r_in);
    end
    if (cmd.step) begin
      m_addr  <= step_addr;
      m_in    <= step_inside;
      dist_ok <= dsum <= QW'(r2);
      ln_r    <= ln;
      ld_r    <= ld;
      rn_r    <= rn;
      rd_r    <= rd;
    end
    if (cmd.capture || cmd.step) begin
      opq_rd <= opq_mem[rd_addr];
      vis_rd <= vis_mem[rd_addr];
      exp_rd <= exp_mem[rd_addr];
    end
  end

  // scan frame and stack control
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      sp       <= '0;
      oct      <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.sweep_all || cmd.sweep_vis) clr_addr <= clr_addr + AW'(1);
      if (cmd.capture) oct <= '0;
      else if (cmd.oct_next) oct <= oct + 3'd1;
      if (cmd.oct_init) begin
        active     <= 1'b1;
        sp         <= '0;
        fr.j       <= JW'(1);
        fr.dx      <= -DX_ONE;
        fr.sn      <= S_ONE;
        fr.sd      <= S_ONE;
        fr.en      <= S_ZERO;
        fr.ed      <= S_ONE;
        fr.nn      <= S_ZERO;
        fr.nd      <= S_ONE;
        fr.blocked <= 1'b0;
      end else if (cmd.step) begin
        if (!active) begin
          if (sp != '0) sp <= sp - NW'(1);
        end else if (dx_pos) begin
          if (fr.blocked) begin
            active <= 1'b0;
          end else begin
            fr.j  <= jn;
            fr.dx <= -signed'({1'b0, jn});
          end
        end else if (j_over) begin
          active <= 1'b0;
        end
      end else if (cmd.pop_load) begin
        fr     <= stk_rd;
        active <= 1'b1;
      end else if (cmd.test) begin
        if (c1) fr.dx <= fr.dx + DX_ONE;
        else if (c2) fr.dx <= DX_ONE;
      end else if (cmd.mark) begin
        if (do_push) begin
          fr <= f_new;
          sp <= sp + NW'(1);
        end else begin
          fr <= f_mark;
        end
      end
    end
  end

  // frame stack memory
  always_ff @(posedge clk) begin
    if (cmd.mark && do_push) stack_mem[sp[IW-1:0]] <= f_mark;
    if (cmd.step && !active && sp != '0) stk_rd <= stack_mem[sp[IW-1:0] - IW'(1)];
  end

  // tile memories
  always_ff @(posedge clk) begin
    if (cmd.sweep_all) opq_mem[clr_addr] <= 1'b0;
    else if (cmd.wr_opq && in_inside) opq_mem[in_addr] <= opaque_in;
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_all || cmd.sweep_vis) vis_mem[clr_addr] <= 1'b0;
    else if (cmd.origin_mark && orig_in) vis_mem[o_addr] <= 1'b1;
    else if (cmd.mark && m_in && dist_ok) vis_mem[m_addr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_all) exp_mem[clr_addr] <= 1'b0;
    else if (cmd.origin_mark && orig_in) exp_mem[o_addr] <= 1'b1;
    else if (cmd.mark && m_in && dist_ok) exp_mem[m_addr] <= 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_now) begin
      vis_o <= 1'b0;
      exp_o <= 1'b0;
      inm_o <= (action == ACT_WRITE) && in_inside;
    end else if (cmd.out_read) begin
      vis_o <= orig_in && vis_rd;
      exp_o <= orig_in && exp_rd;
      inm_o <= orig_in;
    end else if (cmd.out_fin) begin
      vis_o <= 1'b0;
      exp_o <= 1'b0;
      inm_o <= orig_in;
    end
  end

  assign visible_out  = vis_o;
  assign explored_out = exp_o;
  assign in_map       = inm_o;

  assign stat.sweep_done  = &clr_addr;
  assign stat.visit       = active && !dx_pos && !j_over;
  assign stat.active      = active;
  assign stat.stack_empty = (sp == '0);
  assign stat.oct_last    = (oct == 3'd7);
  assign stat.test_pass   = !c1 && !c2;

endmodule

>>> design/sfov_ctrl.sv
// controller: sequences item handling, memory sweeps and the octant scan
// depends on sfov_pkg
module sfov_ctrl import sfov_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  output logic       out_valid,
  input  logic       out_stall,
  output sfov_cmd_t  cmd,
  input  sfov_stat_t stat
);

  typedef enum logic [10:0] {
    S_CLR_ALL = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_READ    = 11'b00000000100,
    S_CLR_VIS = 11'b00000001000,
    S_ORIGIN  = 11'b00000010000,
    S_OCT     = 11'b00000100000,
    S_STEP    = 11'b00001000000,
    S_POP     = 11'b00010000000,
    S_TEST    = 11'b00100000000,
    S_MARK    = 11'b01000000000,
    S_FIN     = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic accept, out_load;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLR_ALL: begin
        cmd.sweep_all = 1'b1;
        if (stat.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          case (action)
            ACT_WRITE: begin
              cmd.wr_opq  = 1'b1;
              cmd.out_now = 1'b1;
            end
            ACT_COMPUTE: state_next = S_CLR_VIS;
            ACT_READ:    state_next = S_READ;
            default:     cmd.out_now = 1'b1;
          endcase
        end
      end
      S_READ: begin
        cmd.out_read = 1'b1;
        state_next = S_IDLE;
      end
      S_CLR_VIS: begin
        cmd.sweep_vis = 1'b1;
        if (stat.sweep_done) state_next = S_ORIGIN;
      end
      S_ORIGIN: begin
        cmd.origin_mark = 1'b1;
        state_next = S_OCT;
      end
      S_OCT: begin
        cmd.oct_init = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.visit) begin
          state_next = S_TEST;
        end else if (!stat.active) begin
          if (!stat.stack_empty) begin
            state_next = S_POP;
          end else if (stat.oct_last) begin
            state_next = S_FIN;
          end else begin
            cmd.oct_next = 1'b1;
            state_next = S_OCT;
          end
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next = S_STEP;
      end
      S_TEST: begin
        cmd.test = 1'b1;
        state_next = stat.test_pass ? S_MARK : S_STEP;
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        state_next = S_STEP;
      end
      S_FIN: begin
        cmd.out_fin = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_load = cmd.out_now || cmd.out_read || cmd.out_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR_ALL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule

>>> design/shadowcast_field_of_view.sv
// top level of the shadowcast field-of-view block: controller plus datapath
// depends on sfov_pkg, sfov_ctrl, sfov_datapath
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid / in_stall     | action, tile_x, tile_y, opaque_in, view_radius
//   out     | out_valid / out_stall   | visible_out, explored_out, in_map
//   cfg     | cfg_write_en            | cfg_index, cfg_data
//
// write and unused actions: the result is registered when the transaction is accepted
// read: the tile memory read is registered, then the result register loads from it
// compute: a visible-bit sweep over every tile address, an origin mark, then per octant a
//   start state, then a step, slope test and mark per marked cell, a step and slope test
//   per cell cut by the test, a step per row advance or frame end and a step and frame
//   load per stack pop
// after reset all three tile memories are swept, with in_stall high throughout
// one item at a time; a result waiting under out_stall holds off new input
module shadowcast_field_of_view import sfov_pkg::*; #(
  parameter int MAP_SIDE_MAX = MAP_SIDE_MAX_DEF,
  parameter int RADIUS_MAX   = RADIUS_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       action,
  input  logic [5:0]       tile_x,
  input  logic [5:0]       tile_y,
  input  logic             opaque_in,
  input  logic [4:0]       view_radius,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             visible_out,
  output logic             explored_out,
  output logic             in_map
);

  sfov_cmd_t  cmd;
  sfov_stat_t stat;

  // sequencer: sweeps, octant loop, frame stack pops
  sfov_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // tile memories, scan frame, slope compare and range check
  sfov_datapath #(
    .MAP_SIDE_MAX (MAP_SIDE_MAX),
    .RADIUS_MAX   (RADIUS_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .tile_x       (tile_x),
    .tile_y       (tile_y),
    .opaque_in    (opaque_in),
    .view_radius  (view_radius),
    .visible_out  (visible_out),
    .explored_out (explored_out),
    .in_map       (in_map)
  );

endmodule

>>> design/sfov_checker.sv
// port-level checks for the shadowcast field-of-view block
// depends on sfov_pkg; bound to shadowcast_field_of_view
module sfov_checker import sfov_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] action,
  input logic       out_valid,
  input logic       out_stall,
  input logic       visible_out,
  input logic       explored_out,
  input logic       in_map
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  // visible tiles are always explored
  a_vis_exp: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible_out |-> explored_out)
    else $error("visible without explored");

  // tile bits only for tiles in the map
  a_bits_in_map: assert property (@(posedge clk) disable iff (rst)
    out_valid && explored_out |-> in_map)
    else $error("tile bits outside map");

  // a compute transaction keeps the input stalled next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_COMPUTE |=> in_stall)
    else $error("input taken during compute");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind shadowcast_field_of_view sfov_checker u_sfov_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .action       (action),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .visible_out  (visible_out),
  .explored_out (explored_out),
  .in_map       (in_map)
);
